/* hdl/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and a helper function of the LZW variable width decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int DICT_ENTRIES_DEF  = 4096;
    localparam int CNT_W             = 24;
    localparam int BUF_W             = 24;
    localparam int HELD_W            = 5;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SKIP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = 24'hFFFFFF;

    localparam int CODE_END    = 256;
    localparam int CODE_CLEAR  = 257;
    localparam int FIRST_FREE  = 258;
    localparam int START_BITS  = 9;
    localparam int START_LIMIT = 512;

    function automatic logic [7:0] rotr3(input logic [7:0] b);
        return {b[2:0], b[7:3]};
    endfunction

endpackage

/* hdl/lzwd_in_if.sv */
// ----------------------------------------------------------------------------
// lzwd_in_if
// Input channel: func and in_byte with valid/ready.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;
    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

/* hdl/lzwd_out_if.sv */
// ----------------------------------------------------------------------------
// lzwd_out_if
// Output channel: one result per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       need_input;
    logic       done_res;
    modport source (output valid, output out_byte, output out_valid,
                    output need_input, output done_res, input ready);
    modport sink   (input valid, input out_byte, input out_valid,
                    input need_input, input done_res, output ready);
endinterface

/* hdl/lzwd_ram.sv */
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hdl/lzw_variable_width_decoder.sv */
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// LZW decoder, LSB-first codes of 9 up to MAX_CODE_BITS bits, with byte
// skip, write limit and rotated output.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | func, in_byte
//  out_ch   | out | out_byte, out_valid, need_input, done_res
//  cfg      | in  | cfg_we, cfg_idx, cfg_data (skip_count, limit_count)
//
//  A push buffers its byte, unless done or the buffer is full, and answers
//  through S_RESP. A pull pops the stack through S_POP and S_POPD, going
//  back to S_POP for each skipped byte; with an empty stack it decodes a
//  code in S_CODE, walking a data code's chain in S_WALK and S_WALKD and
//  ending in S_ROOT. The single port dictionary and stack RAMs take one access per cycle each.
//  Reset clears all control state; the RAMs hold no reset value.
//  A result waits in the output register; the next transaction can be
//  taken from the cycle after it has gone.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder #(
    parameter int MAX_CODE_BITS = lzwd_pkg::MAX_CODE_BITS_DEF,
    parameter int DICT_ENTRIES  = lzwd_pkg::DICT_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lzwd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [lzwd_pkg::CNT_W-1:0]     cfg_data,
    lzwd_in_if.sink                        in_ch,
    lzwd_out_if.source                     out_ch
);
    localparam int AW  = $clog2(DICT_ENTRIES);
    localparam int SW  = AW + 1;
    localparam int CW  = MAX_CODE_BITS;
    localparam int NW  = $clog2(DICT_ENTRIES + 1) > CW + 1 ?
                         $clog2(DICT_ENTRIES + 1) : CW + 1;
    localparam int WW  = $clog2(CW + 1);
    localparam int LW  = CW + 2;
    localparam int CNT_W = lzwd_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_POPD  = 4'd2;
    localparam logic [3:0] S_CODE  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_WALKD = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [CNT_W-1:0] skip_reg, limit_reg, produced_reg, produced_next;
    logic [CNT_W-1:0] written_reg, written_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [lzwd_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [lzwd_pkg::HELD_W-1:0] held_reg, held_next;
    logic [WW-1:0] cw_reg, cw_next;
    logic [LW-1:0] wl_reg, wl_next;
    logic [NW-1:0] nc_reg, nc_next;
    logic [CW-1:0] old_reg, old_next, cur_reg, cur_next, code_reg, code_next;
    logic [7:0]  fc_reg, fc_next;
    logic        done_reg, done_next, clr_reg, clr_next;
    logic        ov_reg, ov_next, res_reg, res_next;
    logic [7:0]  ob_reg, ob_next;

    logic          d_we, s_we;
    logic [AW-1:0] d_addr, s_addr;
    logic [CW-1:0] p_wd, p_rd;
    logic [7:0]    x_wd, x_rd, s_wd, s_rd;

    lzwd_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_prefix
        (.clk(clk), .we(d_we), .addr(d_addr), .wdata(p_wd), .rdata(p_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix
        (.clk(clk), .we(d_we), .addr(d_addr), .wdata(x_wd), .rdata(x_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_stack
        (.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

    logic [CW-1:0]   code_mask;
    logic [CW-1:0]   code_w;
    logic            sp_full, sp_walk_ok;

    always_comb
    begin
        code_mask = CW'((({{(CW){1'b0}}, 1'b1}) << cw_reg) - 1'b1);
        code_w    = buf_reg[CW-1:0] & code_mask;
        sp_full   = (sp_reg >= SW'(DICT_ENTRIES));
        sp_walk_ok = (sp_reg < SW'(DICT_ENTRIES - 1));
    end

    always_comb
    begin
        state_next    = state_reg;
        produced_next = produced_reg;
        written_next  = written_reg;
        sp_next       = sp_reg;
        buf_next      = buf_reg;
        held_next     = held_reg;
        cw_next       = cw_reg;
        wl_next       = wl_reg;
        nc_next       = nc_reg;
        old_next      = old_reg;
        cur_next      = cur_reg;
        code_next     = code_reg;
        fc_next       = fc_reg;
        done_next     = done_reg;
        clr_next      = clr_reg;
        ov_next       = ov_reg;
        ob_next       = ob_reg;
        res_next      = res_reg;
        d_we   = 1'b0;
        d_addr = cur_reg[AW-1:0];
        p_wd   = old_reg;
        x_wd   = fc_reg;
        s_we   = 1'b0;
        s_addr = sp_reg[AW-1:0];
        s_wd   = fc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    ov_next = 1'b0;
                    ob_next = '0;
                    if (!in_ch.func)
                    begin
                        if (!done_reg && held_reg <= 5'd16)
                        begin
                            buf_next = buf_reg |
                                (lzwd_pkg::BUF_W'(in_ch.in_byte) << held_reg);
                            held_next = held_reg + 5'd8;
                        end
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                priority if (done_reg)
                begin
                    state_next = S_RESP;
                end
                else if (sp_reg != '0)
                begin
                    sp_next = sp_reg - 1'b1;
                    s_addr  = sp_next[AW-1:0];
                    state_next = S_POPD;
                end
                else if (5'(held_reg) < 5'(cw_reg))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    code_next = code_w;
                    buf_next  = buf_reg >> cw_reg;
                    held_next = held_reg - 5'(cw_reg);
                    state_next = S_CODE;
                end
            end
            S_POPD:
            begin
                priority if (produced_reg < skip_reg)
                begin
                    produced_next = produced_reg + 1'b1;
                    state_next = S_POP;
                end
                else if (limit_reg != '0 && written_reg == limit_reg)
                begin
                    done_next = 1'b1;
                    sp_next   = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    if (written_reg != lzwd_pkg::CNT_MAX)
                        written_next = written_reg + 1'b1;
                    if (produced_reg != lzwd_pkg::CNT_MAX)
                        produced_next = produced_reg + 1'b1;
                    ob_next = lzwd_pkg::rotr3(s_rd);
                    ov_next = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_CODE:
            begin
                priority if (clr_reg)
                begin
                    clr_next = 1'b0;
                    old_next = code_reg;
                    fc_next  = code_reg[7:0];
                    s_we   = !sp_full;
                    s_wd   = code_reg[7:0];
                    if (!sp_full) sp_next = sp_reg + 1'b1;
                    state_next = S_POP;
                end
                else if (NW'(code_reg) == NW'(lzwd_pkg::CODE_END))
                begin
                    done_next = 1'b1;
                    state_next = S_POP;
                end
                else if (NW'(code_reg) == NW'(lzwd_pkg::CODE_CLEAR))
                begin
                    cw_next = WW'(lzwd_pkg::START_BITS);
                    wl_next = LW'(lzwd_pkg::START_LIMIT);
                    nc_next = NW'(lzwd_pkg::FIRST_FREE);
                    clr_next = 1'b1;
                    state_next = S_POP;
                end
                else if (NW'(code_reg) >= nc_reg)
                begin
                    s_we = !sp_full;
                    s_wd = fc_reg;
                    if (!sp_full) sp_next = sp_reg + 1'b1;
                    cur_next = old_reg;
                    state_next = S_WALK;
                end
                else
                begin
                    cur_next = code_reg;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (cur_reg > CW'(8'hFF) && sp_walk_ok)
                begin
                    d_addr = cur_reg[AW-1:0];
                    state_next = S_WALKD;
                end
                else
                begin
                    state_next = S_ROOT;
                end
            end
            S_WALKD:
            begin
                s_we = 1'b1;
                s_wd = (NW'(cur_reg) < NW'(DICT_ENTRIES)) ? x_rd : 8'h00;
                sp_next = sp_reg + 1'b1;
                cur_next = (NW'(cur_reg) < NW'(DICT_ENTRIES)) ? p_rd : '0;
                state_next = S_WALK;
            end
            S_ROOT:
            begin
                fc_next = cur_reg[7:0];
                s_we = !sp_full;
                s_wd = cur_reg[7:0];
                if (!sp_full) sp_next = sp_reg + 1'b1;
                if (nc_reg < NW'(DICT_ENTRIES))
                begin
                    d_we   = 1'b1;
                    d_addr = nc_reg[AW-1:0];
                    p_wd   = old_reg;
                    x_wd   = cur_reg[7:0];
                    nc_next = nc_reg + 1'b1;
                end
                if (LW'(nc_next) >= wl_reg && cw_reg != WW'(MAX_CODE_BITS))
                begin
                    cw_next = cw_reg + 1'b1;
                    wl_next = wl_reg << 1;
                end
                old_next = code_reg;
                state_next = S_POP;
            end
            S_RESP:
            begin
                res_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (res_reg && out_ch.ready)
            res_next = 1'b0;
    end

    assign in_ch.ready = (state_reg == S_IDLE) && !res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            skip_reg     <= '0;
            limit_reg    <= '0;
            produced_reg <= '0;
            written_reg  <= '0;
            sp_reg       <= '0;
            buf_reg      <= '0;
            held_reg     <= '0;
            cw_reg       <= WW'(lzwd_pkg::START_BITS);
            wl_reg       <= LW'(lzwd_pkg::START_LIMIT);
            nc_reg       <= NW'(lzwd_pkg::FIRST_FREE);
            old_reg      <= '0;
            fc_reg       <= '0;
            done_reg     <= 1'b0;
            clr_reg      <= 1'b0;
            res_reg      <= 1'b0;
            ov_reg       <= 1'b0;
            ob_reg       <= '0;
        end
        else
        begin
            state_reg    <= (state_reg == S_IDLE && !in_ch.ready) ? S_IDLE : state_next;
            produced_reg <= produced_next;
            written_reg  <= written_next;
            sp_reg       <= sp_next;
            buf_reg      <= (state_reg == S_IDLE && !in_ch.ready) ? buf_reg : buf_next;
            held_reg     <= (state_reg == S_IDLE && !in_ch.ready) ? held_reg : held_next;
            cw_reg       <= cw_next;
            wl_reg       <= wl_next;
            nc_reg       <= nc_next;
            old_reg      <= old_next;
            fc_reg       <= fc_next;
            done_reg     <= done_next;
            clr_reg      <= clr_next;
            res_reg      <= res_next;
            ov_reg       <= (state_reg == S_IDLE && !in_ch.ready) ? ov_reg : ov_next;
            ob_reg       <= (state_reg == S_IDLE && !in_ch.ready) ? ob_reg : ob_next;
            if (cfg_we && cfg_idx == lzwd_pkg::REG_SKIP)
                skip_reg <= cfg_data;
            if (cfg_we && cfg_idx == lzwd_pkg::REG_LIMIT)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        code_reg <= code_next;
    end

    assign out_ch.valid      = res_reg;
    assign out_ch.out_byte   = ob_reg;
    assign out_ch.out_valid  = ov_reg;
    assign out_ch.done_res   = done_reg;
    assign out_ch.need_input = !done_reg && (sp_reg == '0) &&
                               (5'(held_reg) < 5'(cw_reg));
endmodule
